@@ src/rotation_matrix_to_quaternion_defines.svh @@
// Assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
// same-cycle implication
`define RMQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define RMQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ src/rmq_pkg.sv @@
// Shared types for the rotation matrix to quaternion pipeline
`default_nettype none
package rmq_pkg;
   typedef enum logic [1:0] {BR_W, BR_X, BR_Y, BR_Z} branch_type;
   typedef struct packed {
      branch_type         branch;
      logic signed [16:0] n0;
      logic signed [16:0] n1;
      logic signed [16:0] n2;
   } side_type;
endpackage
`default_nettype wire

@@ src/rmq_front.sv @@
// Trace and branch selection, radicand and numerator set-up
`default_nettype none
module rmq_front #(
   parameter int FRAC_BITS = 14,
   parameter int RW = 24
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 en,
   input  wire                 in_valid,
   input  wire [143:0]         in_data,
   output logic                out_valid,
   output logic [2*RW-1:0]     out_v,
   output rmq_pkg::side_type   out_side
);
   localparam int UW = FRAC_BITS + 19;
   localparam int VW = 2 * RW;
   localparam logic signed [UW-1:0] ONE = UW'(1) << FRAC_BITS;

   logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   logic signed [17:0] t;
   logic signed [UW-1:0] u;
   logic [VW-1:0] v_in;
   rmq_pkg::side_type side_in;
   logic valid_ff;
   logic [VW-1:0] v_ff;
   rmq_pkg::side_type side_ff;

   assign m00 = in_data[15:0];
   assign m01 = in_data[31:16];
   assign m02 = in_data[47:32];
   assign m10 = in_data[63:48];
   assign m11 = in_data[79:64];
   assign m12 = in_data[95:80];
   assign m20 = in_data[111:96];
   assign m21 = in_data[127:112];
   assign m22 = in_data[143:128];
   assign t = 18'(m00) + 18'(m11) + 18'(m22);

   always_comb begin
      if (t > 18'sd0) begin
         u = UW'(t) + ONE;
         side_in.branch = rmq_pkg::BR_W;
         side_in.n0 = 17'(m21) - 17'(m12);
         side_in.n1 = 17'(m02) - 17'(m20);
         side_in.n2 = 17'(m10) - 17'(m01);
      end else if (m00 > m11 && m00 > m22) begin
         u = ONE + UW'(m00) - UW'(m11) - UW'(m22);
         side_in.branch = rmq_pkg::BR_X;
         side_in.n0 = 17'(m21) - 17'(m12);
         side_in.n1 = 17'(m01) + 17'(m10);
         side_in.n2 = 17'(m02) + 17'(m20);
      end else if (m11 > m22) begin
         u = ONE + UW'(m11) - UW'(m00) - UW'(m22);
         side_in.branch = rmq_pkg::BR_Y;
         side_in.n0 = 17'(m02) - 17'(m20);
         side_in.n1 = 17'(m01) + 17'(m10);
         side_in.n2 = 17'(m12) + 17'(m21);
      end else begin
         u = ONE + UW'(m22) - UW'(m00) - UW'(m11);
         side_in.branch = rmq_pkg::BR_Z;
         side_in.n0 = 17'(m10) - 17'(m01);
         side_in.n1 = 17'(m02) + 17'(m20);
         side_in.n2 = 17'(m12) + 17'(m21);
      end
      if (u > UW'(0))
         v_in = VW'($unsigned(u)) << FRAC_BITS;
      else
         v_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         v_ff <= v_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_v = v_ff;
   assign out_side = side_ff;
endmodule
`default_nettype wire

@@ src/rmq_sqrt.sv @@
// Pipelined integer square root, one root bit per stage
`default_nettype none
module rmq_sqrt #(
   parameter int RW = 24
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 en,
   input  wire                 in_valid,
   input  wire [2*RW-1:0]      in_v,
   input  rmq_pkg::side_type   in_side,
   output logic                out_valid,
   output logic [RW-1:0]       out_root,
   output rmq_pkg::side_type   out_side
);
   logic              valid_a [0:RW];
   logic [2*RW-1:0]   v_a     [0:RW];
   logic [RW+1:0]     rem_a   [0:RW];
   logic [RW-1:0]     root_a  [0:RW];
   rmq_pkg::side_type side_a  [0:RW];

   assign valid_a[0] = in_valid;
   assign v_a[0] = in_v;
   assign rem_a[0] = '0;
   assign root_a[0] = '0;
   assign side_a[0] = in_side;

   for (genvar s = 0; s < RW; s++) begin : g_stage
      localparam int I = RW - 1 - s;
      logic [RW+1:0] rem_sh;
      logic [RW+1:0] trial;
      logic          fit;
      logic          valid_ff;
      logic [2*RW-1:0] v_ff;
      logic [RW+1:0] rem_ff;
      logic [RW-1:0] root_ff;
      rmq_pkg::side_type side_ff;

      assign rem_sh = {rem_a[s][RW-1:0], v_a[s][2*I+1 -: 2]};
      assign trial = {root_a[s], 2'b01};
      assign fit = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= valid_a[s];
         end
         if (en) begin
            v_ff <= v_a[s];
            rem_ff <= fit ? rem_sh - trial : rem_sh;
            root_ff <= {root_a[s][RW-2:0], fit};
            side_ff <= side_a[s];
         end
      end

      assign valid_a[s+1] = valid_ff;
      assign v_a[s+1] = v_ff;
      assign rem_a[s+1] = rem_ff;
      assign root_a[s+1] = root_ff;
      assign side_a[s+1] = side_ff;
   end

   assign out_valid = valid_a[RW];
   assign out_root = root_a[RW];
   assign out_side = side_a[RW];
endmodule
`default_nettype wire

@@ src/rmq_div.sv @@
// Three-lane pipelined divider, rounding, saturation and component placement
`default_nettype none
module rmq_div #(
   parameter int FRAC_BITS = 14,
   parameter int RW = 24
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 en,
   input  wire                 in_valid,
   input  wire [RW-1:0]        in_root,
   input  rmq_pkg::side_type   in_side,
   output logic                out_valid,
   output logic [63:0]         out_data
);
   localparam int CW = RW + 17;
   localparam int QB = 15;

   logic              valid_a [0:QB];
   logic [CW-1:0]     rem_a   [0:QB][0:2];
   logic [QB-1:0]     q_a     [0:QB][0:2];
   logic              neg_a   [0:QB][0:2];
   logic              zero_a  [0:QB][0:2];
   logic              ovf_a   [0:QB][0:2];
   logic [CW-1:0]     d_a     [0:QB];
   logic [15:0]       half_a  [0:QB];
   rmq_pkg::branch_type br_a  [0:QB];

   logic signed [16:0] num [0:2];
   logic [16:0]        mag [0:2];
   logic [CW-1:0]      n_in [0:2];
   logic [CW-1:0]      d_in;
   logic [RW:0]        half_full;
   logic [15:0]        half_in;

   logic              s0_valid_ff;
   logic [CW-1:0]     s0_rem_ff  [0:2];
   logic              s0_neg_ff  [0:2];
   logic              s0_zero_ff [0:2];
   logic              s0_ovf_ff  [0:2];
   logic [CW-1:0]     s0_d_ff;
   logic [15:0]       s0_half_ff;
   rmq_pkg::branch_type s0_br_ff;

   assign num[0] = in_side.n0;
   assign num[1] = in_side.n1;
   assign num[2] = in_side.n2;
   assign d_in = CW'(in_root) << 1;
   assign half_full = (RW+1)'(in_root) + (RW+1)'(1);
   assign half_in = (half_full[RW:1] > (RW)'(32767)) ? 16'd32767 : 16'(half_full[RW:1]);

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mag[l] = num[l][16] ? 17'(-num[l]) : 17'(num[l]);
         n_in[l] = (CW'(mag[l]) << FRAC_BITS) + CW'(in_root);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= in_valid;
      end
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            s0_rem_ff[l] <= n_in[l];
            s0_neg_ff[l] <= num[l][16];
            s0_zero_ff[l] <= (num[l] == 17'sd0);
            s0_ovf_ff[l] <= n_in[l] >= (d_in << QB);
         end
         s0_d_ff <= d_in;
         s0_half_ff <= half_in;
         s0_br_ff <= in_side.branch;
      end
   end

   assign valid_a[0] = s0_valid_ff;
   assign d_a[0] = s0_d_ff;
   assign half_a[0] = s0_half_ff;
   assign br_a[0] = s0_br_ff;
   for (genvar l = 0; l < 3; l++) begin : g_lane0
      assign rem_a[0][l] = s0_rem_ff[l];
      assign q_a[0][l] = '0;
      assign neg_a[0][l] = s0_neg_ff[l];
      assign zero_a[0][l] = s0_zero_ff[l];
      assign ovf_a[0][l] = s0_ovf_ff[l];
   end

   for (genvar j = 0; j < QB; j++) begin : g_stage
      localparam int K = QB - 1 - j;
      logic              valid_ff;
      logic [CW-1:0]     rem_ff  [0:2];
      logic [QB-1:0]     q_ff    [0:2];
      logic              neg_ff  [0:2];
      logic              zero_ff [0:2];
      logic              ovf_ff  [0:2];
      logic [CW-1:0]     d_ff;
      logic [15:0]       half_ff;
      rmq_pkg::branch_type br_ff;
      logic [CW-1:0]     dk;

      assign dk = d_a[j] << K;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= valid_a[j];
         end
         if (en) begin
            for (int l = 0; l < 3; l++) begin
               if (rem_a[j][l] >= dk) begin
                  rem_ff[l] <= rem_a[j][l] - dk;
                  q_ff[l] <= q_a[j][l] | (QB'(1) << K);
               end else begin
                  rem_ff[l] <= rem_a[j][l];
                  q_ff[l] <= q_a[j][l];
               end
               neg_ff[l] <= neg_a[j][l];
               zero_ff[l] <= zero_a[j][l];
               ovf_ff[l] <= ovf_a[j][l];
            end
            d_ff <= d_a[j];
            half_ff <= half_a[j];
            br_ff <= br_a[j];
         end
      end

      assign valid_a[j+1] = valid_ff;
      assign d_a[j+1] = d_ff;
      assign half_a[j+1] = half_ff;
      assign br_a[j+1] = br_ff;
      for (genvar l = 0; l < 3; l++) begin : g_lane
         assign rem_a[j+1][l] = rem_ff[l];
         assign q_a[j+1][l] = q_ff[l];
         assign neg_a[j+1][l] = neg_ff[l];
         assign zero_a[j+1][l] = zero_ff[l];
         assign ovf_a[j+1][l] = ovf_ff[l];
      end
   end

   logic [15:0] lane_val [0:2];
   logic [63:0] data_in;
   logic        out_valid_ff;
   logic [63:0] out_data_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (zero_a[QB][l])
            lane_val[l] = 16'd0;
         else if (ovf_a[QB][l])
            lane_val[l] = neg_a[QB][l] ? 16'h8000 : 16'h7fff;
         else if (neg_a[QB][l])
            lane_val[l] = 16'(-{1'b0, q_a[QB][l]});
         else
            lane_val[l] = {1'b0, q_a[QB][l]};
      end
      case (br_a[QB])
         rmq_pkg::BR_W: data_in = {lane_val[2], lane_val[1], lane_val[0], half_a[QB]};
         rmq_pkg::BR_X: data_in = {lane_val[2], lane_val[1], half_a[QB], lane_val[0]};
         rmq_pkg::BR_Y: data_in = {lane_val[2], half_a[QB], lane_val[1], lane_val[0]};
         rmq_pkg::BR_Z: data_in = {half_a[QB], lane_val[2], lane_val[1], lane_val[0]};
         default:       data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_a[QB];
      end
      if (en) begin
         out_data_ff <= data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data = out_data_ff;
endmodule
`default_nettype wire

@@ src/rotation_matrix_to_quaternion.sv @@
// Throughput: one matrix per cycle while no result is stalled; the square root gives
// one bit per stage and the dividers one quotient bit per stage, all stages advancing
// together.
// A stalled result holds the whole pipeline until it is taken.
// Reset clears the valid bits only; the data registers are not reset.
`default_nettype none
`include "rotation_matrix_to_quaternion_defines.svh"
module rotation_matrix_to_quaternion #(
   parameter int FRAC_BITS = 14
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [143:0] req_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [63:0]  rsp_tdata   // quat_w, quat_x, quat_y, quat_z
);
   localparam int RW = FRAC_BITS + 10;

   logic en;
   logic f_valid;
   logic [2*RW-1:0] f_v;
   rmq_pkg::side_type f_side;
   logic s_valid;
   logic [RW-1:0] s_root;
   rmq_pkg::side_type s_side;

   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   rmq_front #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_front (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_tvalid), .in_data(req_tdata),
      .out_valid(f_valid), .out_v(f_v), .out_side(f_side)
   );

   rmq_sqrt #(.RW(RW)) u_sqrt (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(f_valid), .in_v(f_v), .in_side(f_side),
      .out_valid(s_valid), .out_root(s_root), .out_side(s_side)
   );

   rmq_div #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_div (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s_valid), .in_root(s_root), .in_side(s_side),
      .out_valid(rsp_tvalid), .out_data(rsp_tdata)
   );

   `RMQ_ASSERT_NOW(a_ready_follows_out, clock, reset, 1'b1, req_tready == (!rsp_tvalid || rsp_tready), "input ready does not follow output stall")
   `RMQ_ASSERT_NEXT(a_stall_holds, clock, reset, !req_tready, $stable(rsp_tdata) && rsp_tvalid, "result changed during stall")
   `RMQ_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_tvalid, "result valid right after reset")
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the rotation matrix to quaternion pipeline
`timescale 1ns / 1ps
module testbench;
   localparam int FRAC = 14;
   localparam int LATENCY = FRAC + 28;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [143:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_type;

   quat_type quat_queue[$];
   int errors = 0;
   int idle_cycles = 0;
   bit hold_off = 1'b0;
   int burst_left = 0;

   rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint int_sqrt(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint fixed_root(longint u);
      if (u <= 0) return 0;
      return int_sqrt(u <<< FRAC);
   endfunction

   function automatic longint scaled_div(longint num, longint r);
      longint mag, q;
      if (r == 0) return num > 0 ? 32767 : (num < 0 ? -32768 : 0);
      mag = num < 0 ? -num : num;
      q = ((mag <<< FRAC) + r) / (2 * r);
      if (q > 40000) q = 40000;
      return num < 0 ? -q : q;
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic quat_type matrix_to_quat(logic [143:0] d);
      longint m[9];
      longint one, t, r, w, x, y, z;
      quat_type q;
      for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[16*i +: 16]));
      one = 64'sd1 <<< FRAC;
      t = m[0] + m[4] + m[8];
      if (t > 0) begin
         r = fixed_root(t + one);
         w = (r + 1) >>> 1;
         x = scaled_div(m[7] - m[5], r);
         y = scaled_div(m[2] - m[6], r);
         z = scaled_div(m[3] - m[1], r);
      end else if (m[0] > m[4] && m[0] > m[8]) begin
         r = fixed_root(one + m[0] - m[4] - m[8]);
         w = scaled_div(m[7] - m[5], r);
         x = (r + 1) >>> 1;
         y = scaled_div(m[1] + m[3], r);
         z = scaled_div(m[2] + m[6], r);
      end else if (m[4] > m[8]) begin
         r = fixed_root(one + m[4] - m[0] - m[8]);
         w = scaled_div(m[2] - m[6], r);
         x = scaled_div(m[1] + m[3], r);
         y = (r + 1) >>> 1;
         z = scaled_div(m[5] + m[7], r);
      end else begin
         r = fixed_root(one + m[8] - m[0] - m[4]);
         w = scaled_div(m[3] - m[1], r);
         x = scaled_div(m[2] + m[6], r);
         y = scaled_div(m[5] + m[7], r);
         z = (r + 1) >>> 1;
      end
      q.w = clamp16(w);
      q.x = clamp16(x);
      q.y = clamp16(y);
      q.z = clamp16(z);
      return q;
   endfunction

   function automatic logic [143:0] pack_matrix(int e[9]);
      logic [143:0] d;
      for (int i = 0; i < 9; i++) d[16*i +: 16] = e[i][15:0];
      return d;
   endfunction

   task automatic report(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t: mismatch %s got %0d want %0d", $realtime, what,
               $signed(got), $signed(want));
      errors++;
   endtask

   task automatic send_matrix(logic [143:0] d);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      quat_queue.push_back(matrix_to_quat(d));
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   // unpack w, x, y, z from the lowest bit up
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         quat_type got, want;
         got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tdata[63:48]};
         if (quat_queue.size() == 0) begin
            $display("%0t: result with none expected", $realtime);
            errors++;
         end else begin
            want = quat_queue.pop_front();
            if (got.w !== want.w) report("quat_w", got.w, want.w);
            if (got.x !== want.x) report("quat_x", got.x, want.x);
            if (got.y !== want.y) report("quat_y", got.y, want.y);
            if (got.z !== want.z) report("quat_z", got.z, want.z);
         end
      end
   end

   always @(negedge clock) begin
      int p;
      p = $urandom_range(0, 99);
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= (p < 70) || ((($time / 10) % 400) < 100);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      int e[9];
      int vals[6] = '{-32768, 32767, 0, 16384, -16384, 1};
      e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
      send_matrix(pack_matrix(e));
      e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
      send_matrix(pack_matrix(e));
      e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
      send_matrix(pack_matrix(e));
      e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
      send_matrix(pack_matrix(e));
      e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      send_matrix(pack_matrix(e));
      e = '{0, 5, 7, -3, 0, 100, 9, -9, 0};
      send_matrix(pack_matrix(e));
      e = '{-5, 300, -20, 40, -5, 1, 2, 3, -5};
      send_matrix(pack_matrix(e));
      e = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
      send_matrix(pack_matrix(e));
      e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
      send_matrix(pack_matrix(e));
      e = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
      send_matrix(pack_matrix(e));
      e = '{-32768, 32767, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
      send_matrix(pack_matrix(e));
      e = '{-20000, 1, 2, 3, -20000, 4, 5, 6, -20000};
      send_matrix(pack_matrix(e));
      e = '{-100, 32767, 32767, 32767, -100, -32768, 32767, 32767, -200};
      send_matrix(pack_matrix(e));
      for (int k = 0; k < 10; k++) begin
         foreach (e[i]) e[i] = vals[$urandom_range(0, 5)];
         send_matrix(pack_matrix(e));
      end
      stop_sending();
   endtask

   task automatic test_rotations(int count);
      int e[9];
      int a, b, c, s;
      for (int k = 0; k < count; k++) begin
         // axis-aligned rotation or a mixed matrix, with jitter; sign pattern picks the branch
         a = $urandom_range(0, 16384);
         b = int'($sqrt(real'(16384 * 16384 - a * a)));
         c = $urandom_range(0, 3);
         s = $urandom_range(0, 1) ? 1 : -1;
         e = '{16384, 0, 0, 0, a, -s * b, 0, s * b, a};
         if (c == 1) e = '{a, 0, s * b, 0, 16384, 0, -s * b, 0, a};
         if (c == 2) e = '{a, -s * b, 0, s * b, a, 0, 0, 0, 16384};
         if (c == 3) e = '{-16384 + a / 8, a, b, a, -16384, b, b, a, 16384 - a};
         foreach (e[i]) e[i] = e[i] + $urandom_range(0, 8) - 4;
         if ($urandom_range(0, 1)) foreach (e[i]) e[i] = ($urandom_range(0, 3) == 0) ? -e[i] : e[i];
         send_matrix(pack_matrix(e));
      end
      stop_sending();
   endtask

   task automatic test_random_bits(int count);
      int e[9];
      for (int k = 0; k < count; k++) begin
         foreach (e[i]) e[i] = $signed(16'($urandom));
         send_matrix(pack_matrix(e));
      end
      stop_sending();
   endtask

   task automatic test_backpressure();
      int e[9];
      hold_off = 1'b1;
      fork
         begin
            repeat (LATENCY * 4) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int k = 0; k < 80; k++) begin
            foreach (e[i]) e[i] = $urandom_range(0, 32767) - 16384;
            send_matrix(pack_matrix(e));
         end
      join
      stop_sending();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_rotations(250);
      test_backpressure();
      test_random_bits(100);
      while (quat_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
